/* hw/rtl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared types, command and status codes.
// ----------------------------------------------------------------------------
package lpht_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam int unsigned KeyW = 64;
  localparam int unsigned IdW  = 32;
  localparam int unsigned AvgW = 32;
  localparam int unsigned EntW = KeyW + IdW + AvgW;
  localparam int unsigned PosW = 7;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,      // capture request, set pointer to home slot
    OP_RD,        // issue read of slot at pointer
    OP_INC,       // pointer + 1
    OP_WRITE,     // write request entry at pointer, mark valid
    OP_CLR,       // clear valid at pointer, remember as hole
    OP_LO_DEC,    // lo scan pointer - 1
    OP_HI_SET,    // pointer <- hole + 1
    OP_PUSH,      // copy read slot into scratch, clear valid
    OP_POP,       // read scratch entry at pop pointer
    OP_POP_LOAD,  // scratch entry becomes current request
    OP_SCAN_LO    // pointer <- hole, for lower bound scan
  } op_e;

  typedef struct packed {
    op_e  op;
    logic set_result;
    logic [1:0] status;
    logic use_found;
  } dp_cmd_t;

  typedef struct packed {
    logic ptr_valid;   // slot at pointer valid (from valid bits)
    logic key_match;   // read key equals request key
    logic ptr_end;     // pointer is beyond last slot
    logic ptr_zero;    // pointer is slot zero
    logic ptr_is_hole; // pointer equals deleted slot
    logic pop_done;    // scratch empty
  } dp_sts_t;

endpackage

/* hw/rtl/lpht_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/lpht_datapath.sv */
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Slot storage, valid bits, probe pointer, scratch queue and result registers.
// ----------------------------------------------------------------------------
module lpht_datapath import lpht_pkg::*; #(
  parameter int unsigned TableSize = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [IdW-1:0]    id_i,
  input  logic [AvgW-1:0]   avg_i,
  output dp_sts_t           sts_o,
  output logic [1:0]        status_o,
  output logic [PosW-1:0]   position_o,
  output logic [IdW-1:0]    found_id_o,
  output logic [AvgW-1:0]   found_avg_o
);

  localparam int unsigned AW = $clog2(TableSize);
  localparam int unsigned PW = AW + 1;

  logic [TableSize-1:0] valid_q;
  logic [KeyW-1:0] key_q;
  logic [IdW-1:0]  id_q;
  logic [AvgW-1:0] avg_q;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [AW-1:0]   hole_q;
  logic [PW-1:0]   push_q, pop_q;
  logic [1:0]      status_q;
  logic [PosW-1:0] pos_q;
  logic [IdW-1:0]  fid_q;
  logic [AvgW-1:0] favg_q;

  logic [EntW-1:0] slot_rdata, scr_rdata;
  logic            slot_we, scr_we;
  logic [AW-1:0]   ptr_idx;

  // Key normalization: the name ends at the first zero byte.
  logic [KeyW-1:0] nkey;
  always_comb begin
    logic alive;
    alive = 1'b1;
    nkey  = '0;
    for (int b = 0; b < 8; b++) begin
      if (key_i[8*b +: 8] == 8'd0) alive = 1'b0;
      if (alive) nkey[8*b +: 8] = key_i[8*b +: 8];
    end
  end

  // Home slot of the current request key (sum of all key bytes modulo TableSize).
  logic [10:0] hsum;
  logic [AW-1:0] home;
  always_comb begin
    hsum = '0;
    for (int b = 0; b < 8; b++) hsum = hsum + 11'(key_q[8*b +: 8]);
  end
  assign home = AW'(32'(hsum) % TableSize);

  assign ptr_idx = ptr_q[AW-1:0];

  assign slot_we = (cmd_i.op == OP_WRITE);
  assign scr_we  = (cmd_i.op == OP_PUSH);

  lpht_ram #(.Width(EntW), .Depth(TableSize)) u_slots (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(ptr_idx),
    .wdata_i({key_q, id_q, avg_q}),
    .raddr_i(ptr_idx),
    .rdata_o(slot_rdata)
  );

  lpht_ram #(.Width(EntW), .Depth(TableSize)) u_scratch (
    .clk_i  (clk_i),
    .we_i   (scr_we),
    .waddr_i(push_q[AW-1:0]),
    .wdata_i(slot_rdata),
    .raddr_i(pop_q[AW-1:0]),
    .rdata_o(scr_rdata)
  );

  always_comb begin
    ptr_d = ptr_q;
    unique case (cmd_i.op)
      OP_LOAD:     ptr_d = '0;
      OP_INC:      ptr_d = ptr_q + PW'(1);
      OP_LO_DEC:   ptr_d = ptr_q - PW'(1);
      OP_HI_SET:   ptr_d = PW'(hole_q) + PW'(1);
      OP_SCAN_LO:  ptr_d = PW'(hole_q);
      OP_POP_LOAD: ptr_d = '0;
      default:     ptr_d = ptr_q;
    endcase
  end

  // Pointer is loaded to home in the cycle after the key register is loaded.
  logic home_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ptr_q       <= '0;
      push_q      <= '0;
      pop_q       <= '0;
      home_pend_q <= 1'b0;
    end else begin
      home_pend_q <= (cmd_i.op == OP_LOAD) || (cmd_i.op == OP_POP_LOAD);
      if (home_pend_q) ptr_q <= PW'(home);
      else             ptr_q <= ptr_d;
      if (cmd_i.op == OP_WRITE) valid_q[ptr_idx] <= 1'b1;
      if (cmd_i.op == OP_CLR || cmd_i.op == OP_PUSH) valid_q[ptr_idx] <= 1'b0;
      if (cmd_i.op == OP_LOAD) begin
        push_q <= '0;
        pop_q  <= '0;
      end
      if (cmd_i.op == OP_PUSH) push_q <= push_q + PW'(1);
      if (cmd_i.op == OP_POP_LOAD) pop_q <= pop_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      key_q <= nkey;
      id_q  <= id_i;
      avg_q <= avg_i;
    end else if (cmd_i.op == OP_POP_LOAD) begin
      key_q <= scr_rdata[EntW-1 -: KeyW];
      id_q  <= scr_rdata[AvgW +: IdW];
      avg_q <= scr_rdata[AvgW-1:0];
    end
    if (cmd_i.op == OP_CLR) hole_q <= ptr_idx;
    if (cmd_i.set_result) begin
      status_q <= cmd_i.status;
      pos_q    <= (cmd_i.status == ST_DONE) ? PosW'(ptr_q) : '0;
      fid_q    <= cmd_i.use_found ? slot_rdata[AvgW +: IdW] : '0;
      favg_q   <= cmd_i.use_found ? slot_rdata[AvgW-1:0] : '0;
    end
  end

  assign sts_o.ptr_valid   = (ptr_q < PW'(TableSize)) && valid_q[ptr_idx];
  assign sts_o.key_match   = (slot_rdata[EntW-1 -: KeyW] == key_q);
  assign sts_o.ptr_end     = (ptr_q >= PW'(TableSize));
  assign sts_o.ptr_zero    = (ptr_q == '0);
  assign sts_o.ptr_is_hole = (ptr_idx == hole_q);
  assign sts_o.pop_done    = (pop_q == push_q);

  assign status_o    = status_q;
  assign position_o  = pos_q;
  assign found_id_o  = fid_q;
  assign found_avg_o = favg_q;

endmodule

/* hw/rtl/lpht_ctrl.sv */
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences probing, cluster removal and reinsertion, and the handshake.
// ----------------------------------------------------------------------------
module lpht_ctrl import lpht_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_HOME    = 4'd1;
  localparam logic [3:0] S_PROBE   = 4'd2;
  localparam logic [3:0] S_RDWAIT  = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_LO      = 4'd5;
  localparam logic [3:0] S_HI      = 4'd6;
  localparam logic [3:0] S_SWEEP   = 4'd7;
  localparam logic [3:0] S_SWRD    = 4'd8;
  localparam logic [3:0] S_POP     = 4'd9;
  localparam logic [3:0] S_POPWAIT = 4'd10;
  localparam logic [3:0] S_RHOME   = 4'd11;
  localparam logic [3:0] S_RPROBE  = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;
  localparam logic [3:0] S_PUSHINC = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] op_q, op_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cmd_o     = '{op: OP_IDLE, set_result: 1'b0, status: ST_NOTFOUND, use_found: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_cmd_i;
          cmd_o.op = OP_LOAD;
          if (in_cmd_i == CMD_NOP) begin
            cmd_o.set_result = 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_HOME;
          end
        end
      end
      S_HOME: state_d = S_PROBE;  // pointer takes home slot
      S_PROBE: begin
        if (sts_i.ptr_end) begin
          cmd_o.set_result = 1'b1;
          cmd_o.status = (op_q == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
          state_d = S_OUT;
        end else if (op_q == CMD_INSERT) begin
          if (!sts_i.ptr_valid) begin
            cmd_o.op = OP_WRITE;
            cmd_o.set_result = 1'b1;
            cmd_o.status = ST_DONE;
            state_d = S_OUT;
          end else begin
            cmd_o.op = OP_INC;
          end
        end else if (!sts_i.ptr_valid) begin
          cmd_o.set_result = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_RD;
          state_d  = S_RDWAIT;
        end
      end
      S_RDWAIT: state_d = S_CHECK;
      S_CHECK: begin
        if (sts_i.key_match) begin
          cmd_o.set_result = 1'b1;
          cmd_o.status = ST_DONE;
          cmd_o.use_found = (op_q == CMD_SEARCH);
          if (op_q == CMD_DELETE) begin
            cmd_o.op  = OP_CLR;
            state_d   = S_LO;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          cmd_o.op = OP_INC;
          state_d  = S_PROBE;
        end
      end
      // Walk down from the hole to find the first slot of the cluster.
      S_LO: begin
        if (!sts_i.ptr_valid && !sts_i.ptr_is_hole) begin
          cmd_o.op = OP_INC;
          state_d  = S_SWEEP;
        end else if (sts_i.ptr_zero) begin
          state_d = S_SWEEP;
        end else begin
          cmd_o.op = OP_LO_DEC;
        end
      end
      // Move every valid cluster slot to scratch; stop at first empty or end.
      S_SWEEP: begin
        if (sts_i.ptr_end) begin
          state_d = S_POP;
        end else if (sts_i.ptr_is_hole) begin
          cmd_o.op = OP_INC;
        end else if (!sts_i.ptr_valid) begin
          state_d = S_POP;
        end else begin
          cmd_o.op = OP_RD;
          state_d  = S_SWRD;
        end
      end
      S_SWRD: state_d = S_HI;
      S_HI: begin
        cmd_o.op = OP_PUSH;
        state_d  = S_PUSHINC;
      end
      S_PUSHINC: begin
        cmd_o.op = OP_INC;
        state_d  = S_SWEEP;
      end
      S_POP: begin
        if (sts_i.pop_done) begin
          state_d = S_OUT;
        end else begin
          state_d = S_POPWAIT;
        end
      end
      S_POPWAIT: begin
        cmd_o.op = OP_POP_LOAD;
        state_d  = S_RHOME;
      end
      S_RHOME: state_d = S_RPROBE;
      S_RPROBE: begin
        if (sts_i.ptr_end) begin
          state_d = S_POP;
        end else if (!sts_i.ptr_valid) begin
          cmd_o.op = OP_WRITE;
          state_d  = S_POP;
        end else begin
          cmd_o.op = OP_INC;
        end
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= CMD_NOP;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
    end
  end

endmodule

/* hw/rtl/linear_probe_hash_table_top.sv */
// An insert responds once its probe reaches an empty slot or the table end; a
// search or delete responds once it hits the key or reaches either of those. A
// delete hit responds only after every other entry of the cluster has gone
// through scratch for reinsertion. One request is in flight at a time; the
// next is accepted in the cycle after the response is taken.
// Reset clears all valid bits at once, so a request is accepted right after it.
// ----------------------------------------------------------------------------
// Linear probe hash table top level
// Open-addressing table with forward probing and cluster rebuild on delete.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top import lpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // cmd[1:0], key[65:2], student_id[97:66], avg_bits[129:98], zero pad
  input  logic [135:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status[1:0], position[8:2], found_id[40:9], found_avg_bits[72:41], pad
  output logic [79:0]   m_axis_tdata
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic [1:0]      status;
  logic [PosW-1:0] position;
  logic [IdW-1:0]  found_id;
  logic [AvgW-1:0] found_avg;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tdata[1:0]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  lpht_datapath #(.TableSize(TABLE_SIZE)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .key_i      (s_axis_tdata[65:2]),
    .id_i       (s_axis_tdata[97:66]),
    .avg_i      (s_axis_tdata[129:98]),
    .sts_o      (dp_sts),
    .status_o   (status),
    .position_o (position),
    .found_id_o (found_id),
    .found_avg_o(found_avg)
  );

  assign m_axis_tdata = {7'd0, found_avg, found_id, position, status};

`ifndef SYNTHESIS
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready and result valid together");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status <= ST_FULL))
    else $error("bad status code");
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status != ST_DONE) |-> (position == '0))
    else $error("position set on failure");
`endif

endmodule
